// ===== sv/tta_pkg.sv =====
// tta_pkg: shared constants, codes, types and the step table of the trackball
// toggle accelerator. Depends on nothing; used by every module of the block.
package tta_pkg;

    // Widths
    localparam int ACCUM_WIDTH      = 16;    // accumulator width, 8..32
    localparam int STEP_TABLE_DEPTH = 64;    // step table entries, 45..256
    localparam int IDX_W            = $clog2(STEP_TABLE_DEPTH);
    localparam int STEP_W           = 12;    // widest table entry is 2693
    localparam int TIME_W           = 32;
    localparam int OUT_W            = 16;
    localparam int KEY_W            = 8;
    localparam int WIN_W            = 16;
    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int KIND_W           = 2;
    localparam int LINE_W           = 2;
    localparam int NUM_LINES        = 4;
    localparam int IN_TDATA_W       = 48;    // 44 bits of fields, padded
    localparam int OUT_TDATA_W      = 40;    // 34 bits of fields, padded
    localparam int OUT_TUSER_W      = 2;

    // Accumulate and saturate widths
    localparam int SUM_W = ((ACCUM_WIDTH > STEP_W) ? ACCUM_WIDTH : STEP_W) + 2;
    localparam int SAT_W = ACCUM_WIDTH + OUT_W + 1;

    localparam logic signed [SUM_W-1:0] ACC_HI = SUM_W'((2**(ACCUM_WIDTH-1)) - 1);
    localparam logic signed [SUM_W-1:0] ACC_LO = ~ACC_HI;
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((2**(OUT_W-1)) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

    // Step curve
    localparam logic [STEP_W-1:0] BASE_STEP   = STEP_W'(3);
    localparam logic [TIME_W-1:0] ROM_LAST_DT = TIME_W'(44);

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LINE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KEY    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE_KEY_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_KEY_B    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WINDOW = 2'd3;

    // Register reset values
    localparam logic [KEY_W-1:0] RST_MODE_KEY_A    = 8'd0;
    localparam logic [KEY_W-1:0] RST_MODE_KEY_B    = 8'd1;
    localparam logic [WIN_W-1:0] RST_IDLE_TIMEOUT  = 16'd30;
    localparam logic [WIN_W-1:0] RST_ACTIVE_WINDOW = 16'd40;

    typedef struct packed {
        logic load_in;    // input transfer, capture the item
        logic calc_step;  // look up step, record new line level and time
        logic add_step;   // saturating add of the step
        logic do_key;     // mode key event
        logic do_report;  // drain accumulators into the output register
    } tta_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              toggle;    // held line sample differs from stored level
        logic              out_busy;  // result waiting and not taken this cycle
    } tta_stat_t;

    // Step size by elapsed ms; entry 0 is never used (dt 0 reads entry 1)
    function automatic logic [STEP_W-1:0] step_rom(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        unique case (idx)
            6'd0, 6'd1: s = 12'd2693;
            6'd2:       s = 12'd90;
            6'd3:       s = 12'd29;
            6'd4:       s = 12'd16;
            6'd5:       s = 12'd12;
            6'd6:       s = 12'd9;
            6'd7:       s = 12'd8;
            6'd8:       s = 12'd7;
            6'd9, 6'd10, 6'd11: s = 12'd6;
            6'd12, 6'd13, 6'd14, 6'd15, 6'd16: s = 12'd5;
            default:    s = 12'd4;   // 17..44; beyond 44 never selected
        endcase
        return s;
    endfunction

    // Clamp a signed accumulator-range value to the 16-bit output field
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [ACCUM_WIDTH:0] v);
        logic signed [SAT_W-1:0] w;
        w = SAT_W'(v);
        if (w > SAT_HI) begin
            w = SAT_HI;
        end else if (w < SAT_LO) begin
            w = SAT_LO;
        end
        return w[OUT_W-1:0];
    endfunction

endpackage

// ===== sv/tta_ctrl.sv =====
// tta_ctrl: sequencer of the trackball toggle accelerator.
// Uses tta_pkg; issues tta_cmd_t commands to tta_datapath from its tta_stat_t.
module tta_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  tta_pkg::tta_stat_t stat,
    output tta_pkg::tta_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_ADD
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == ST_IDLE) || (state_reg == ST_ADD);
        accept     = s_tvalid && s_tready;
        cmd.load_in = accept;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                unique case (stat.kind)
                    tta_pkg::KIND_LINE: begin
                        if (stat.toggle) begin
                            cmd.calc_step = 1'b1;
                            state_next    = ST_ADD;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    tta_pkg::KIND_KEY: begin
                        cmd.do_key = 1'b1;
                        state_next = ST_IDLE;
                    end
                    tta_pkg::KIND_REPORT: begin
                        // wait for the output register to free up
                        if (!stat.out_busy) begin
                            cmd.do_report = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ADD: begin
                cmd.add_step = 1'b1;
                state_next   = accept ? ST_STEP : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/tta_datapath.sv =====
// tta_datapath: line state, step lookup, saturating accumulators, mode keys,
// report logic, configuration registers and output register. Uses tta_pkg.
module tta_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [tta_pkg::KIND_W-1:0]          s_tuser,
    input  logic [tta_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tta_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [tta_pkg::OUT_TUSER_W-1:0]     m_tuser,
    input  logic                                cfg_we,
    input  logic [tta_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tta_pkg::CFG_W-1:0]           cfg_data,
    input  tta_pkg::tta_cmd_t                   cmd,
    output tta_pkg::tta_stat_t                  stat
);

    localparam int AW = tta_pkg::ACCUM_WIDTH;
    localparam int SW = tta_pkg::SUM_W;
    localparam int TW = tta_pkg::TIME_W;

    // Configuration
    logic [tta_pkg::KEY_W-1:0] mode_key_a_reg, mode_key_b_reg;
    logic [tta_pkg::WIN_W-1:0] idle_timeout_reg, active_window_reg;

    // Captured item
    logic [tta_pkg::KIND_W-1:0] in_kind_reg;
    logic [tta_pkg::LINE_W-1:0] in_line_reg;
    logic                       in_level_reg;
    logic [tta_pkg::KEY_W-1:0]  in_pos_reg;
    logic                       in_pressed_reg;
    logic [TW-1:0]              in_time_reg;

    // Block state
    logic [tta_pkg::NUM_LINES-1:0] line_level_reg;
    logic [TW-1:0]                 line_time_reg [tta_pkg::NUM_LINES];
    logic signed [AW-1:0]          x_accum_reg, y_accum_reg;
    logic                          key_a_reg, key_b_reg, moving_reg;
    logic [TW-1:0]                 last_motion_reg;
    logic [tta_pkg::STEP_W-1:0]    step_reg;

    // Output register
    logic                              m_tvalid_reg;
    logic [tta_pkg::OUT_TDATA_W-1:0]   m_tdata_reg;
    logic [tta_pkg::OUT_TUSER_W-1:0]   m_tuser_reg;

    // Step lookup
    logic [TW-1:0]              dt;
    logic [tta_pkg::STEP_W-1:0] step_next;

    // Accumulate
    logic signed [SW-1:0] acc_sel, step_signed, sum, sum_sat;

    // Report
    logic                      nonempty, pointer;
    logic [TW-1:0]             since_last, since_new;
    logic                      moving_next, active_next;
    logic [tta_pkg::OUT_W-1:0] x_out, y_out;
    logic signed [AW:0]        neg_dx, neg_dy, pos_dy;

    always_comb begin
        dt = in_time_reg - line_time_reg[in_line_reg];
        if (dt == '0) begin
            step_next = tta_pkg::step_rom(tta_pkg::IDX_W'(1));
        end else if (dt <= tta_pkg::ROM_LAST_DT) begin
            step_next = tta_pkg::step_rom(dt[tta_pkg::IDX_W-1:0]);
        end else begin
            step_next = tta_pkg::BASE_STEP;
        end
    end

    // Left and up subtract; bit 1 of the line picks Y
    always_comb begin
        acc_sel     = in_line_reg[1] ? SW'(y_accum_reg) : SW'(x_accum_reg);
        step_signed = $signed(SW'(step_reg));
        sum         = in_line_reg[0] ? acc_sel + step_signed : acc_sel - step_signed;
        if (sum > tta_pkg::ACC_HI) begin
            sum_sat = tta_pkg::ACC_HI;
        end else if (sum < tta_pkg::ACC_LO) begin
            sum_sat = tta_pkg::ACC_LO;
        end else begin
            sum_sat = sum;
        end
    end

    always_comb begin
        nonempty    = (x_accum_reg != '0) || (y_accum_reg != '0);
        pointer     = key_a_reg || key_b_reg;
        since_last  = in_time_reg - last_motion_reg;
        since_new   = nonempty ? '0 : since_last;
        moving_next = nonempty || (moving_reg && !(since_last > TW'(idle_timeout_reg)));
        active_next = since_new < TW'(active_window_reg);
        neg_dx      = -(AW+1)'(x_accum_reg);
        neg_dy      = -(AW+1)'(y_accum_reg);
        pos_dy      = (AW+1)'(y_accum_reg);
        x_out       = nonempty ? tta_pkg::sat_out(neg_dx) : '0;
        y_out       = nonempty ? tta_pkg::sat_out(pointer ? neg_dy : pos_dy) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_key_a_reg    <= tta_pkg::RST_MODE_KEY_A;
            mode_key_b_reg    <= tta_pkg::RST_MODE_KEY_B;
            idle_timeout_reg  <= tta_pkg::RST_IDLE_TIMEOUT;
            active_window_reg <= tta_pkg::RST_ACTIVE_WINDOW;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tta_pkg::REG_MODE_KEY_A:    mode_key_a_reg    <= cfg_data[tta_pkg::KEY_W-1:0];
                tta_pkg::REG_MODE_KEY_B:    mode_key_b_reg    <= cfg_data[tta_pkg::KEY_W-1:0];
                tta_pkg::REG_IDLE_TIMEOUT:  idle_timeout_reg  <= cfg_data;
                tta_pkg::REG_ACTIVE_WINDOW: active_window_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Item capture, step register and report payload, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_kind_reg    <= s_tuser;
            in_line_reg    <= s_tdata[1:0];
            in_level_reg   <= s_tdata[2];
            in_pos_reg     <= s_tdata[10:3];
            in_pressed_reg <= s_tdata[11];
            in_time_reg    <= s_tdata[43:12];
        end
        if (cmd.calc_step) begin
            step_reg <= step_next;
        end
        if (cmd.do_report) begin
            m_tdata_reg <= {6'd0, active_next, moving_next, y_out, x_out};
            m_tuser_reg <= {nonempty && !pointer, nonempty};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_level_reg  <= '1;
            for (int i = 0; i < tta_pkg::NUM_LINES; i++) begin
                line_time_reg[i] <= '0;
            end
            x_accum_reg     <= '0;
            y_accum_reg     <= '0;
            key_a_reg       <= 1'b0;
            key_b_reg       <= 1'b0;
            moving_reg      <= 1'b0;
            last_motion_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cmd.calc_step) begin
                line_level_reg[in_line_reg] <= in_level_reg;
                line_time_reg[in_line_reg]  <= in_time_reg;
            end
            if (cmd.add_step) begin
                if (in_line_reg[1]) begin
                    y_accum_reg <= sum_sat[AW-1:0];
                end else begin
                    x_accum_reg <= sum_sat[AW-1:0];
                end
            end
            if (cmd.do_key) begin
                // key A wins when both registers hold the same position
                if (in_pos_reg == mode_key_a_reg) begin
                    key_a_reg <= in_pressed_reg;
                end else if (in_pos_reg == mode_key_b_reg) begin
                    key_b_reg <= in_pressed_reg;
                end
            end
            if (cmd.do_report) begin
                x_accum_reg  <= '0;
                y_accum_reg  <= '0;
                moving_reg   <= moving_next;
                if (nonempty) begin
                    last_motion_reg <= in_time_reg;
                end
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        stat.kind     = in_kind_reg;
        stat.toggle   = in_level_reg != line_level_reg[in_line_reg];
        stat.out_busy = m_tvalid_reg && !m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== sv/trackball_toggle_accelerator.sv =====
// trackball_toggle_accelerator: top level, joins tta_ctrl and tta_datapath.
// Depends on tta_pkg, tta_ctrl and tta_datapath.
//
//  channel  | dir | transfer when          | payload
//  ---------+-----+------------------------+------------------------------------
//  s_       | in  | s_tvalid && s_tready   | tuser kind; tdata line level key time
//  m_       | out | m_tvalid && m_tready   | tuser valid mode; tdata x y moving active
//  cfg_     | in  | cfg_we                 | cfg_index, cfg_data
//
// Each item passes through the sequencer's decode step, then is either done
// or goes on to the saturating accumulate, during which the next item is
// taken. A report waits in decode while the output register holds an
// untaken result. Reset is synchronous, active low, and returns all line, key,
// motion and register state to its defaults with the output channel empty.
module trackball_toggle_accelerator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [47:0]: line[1:0] level[2] key_position[10:3] key_pressed[11]
    //         time_ms[43:12], zero pad
    input  logic [tta_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [1:0]: kind
    input  logic [tta_pkg::KIND_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [39:0]: x_value[15:0] y_value[31:16] moving[32] active[33], zero pad
    output logic [tta_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // [1:0]: report_valid[0] report_mode[1]
    output logic [tta_pkg::OUT_TUSER_W-1:0]    m_tuser,
    input  logic                               cfg_we,
    input  logic [tta_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tta_pkg::CFG_W-1:0]          cfg_data
);

    tta_pkg::tta_cmd_t  cmd;
    tta_pkg::tta_stat_t stat;

    tta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tta_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== sv/tta_checker.sv =====
// tta_checker: port-level assertions for trackball_toggle_accelerator,
// bound to the top level below. Depends on tta_pkg for widths.
module tta_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tta_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic [tta_pkg::OUT_TUSER_W-1:0]  m_tuser
);

    // Output channel comes up empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending right after reset");

    // A stalled result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // An empty report carries zero motion in pointer mode
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == 32'd0 && !m_tuser[1])
        else $error("empty report with motion or scroll mode");

    // Motion always leaves the moving flag set
    a_motion_moving: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[32])
        else $error("motion report without moving flag");

endmodule

bind trackball_toggle_accelerator tta_checker u_tta_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
